### sv/set_assoc_lru_writeback_cache_top_assert.svh
// ----------------------------------------------------------------------------
// Cache assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### sv/salwc_pkg.sv
// ----------------------------------------------------------------------------
// Cache package
// Geometry constants, field codes and the result item type.
// ----------------------------------------------------------------------------
`default_nettype none

package salwc_pkg;

  // Geometry: WAYS and SETS are powers of two.
  localparam int WAYS   = 4;
  localparam int SETS   = 64;
  localparam int ADDR_W = 30;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int SET_W  = $clog2(SETS);
  localparam int RANK_W = $clog2(WAYS);

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  typedef enum logic {
    MEM_READ      = 1'b0,
    MEM_WRITEBACK = 1'b1
  } mem_op_t;

  typedef struct packed {
    mem_op_t           mem_op;
    logic [ADDR_W-1:0] mem_addr;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

### sv/salwc_req_if.sv
// ----------------------------------------------------------------------------
// Cache request channel
// Valid/ready channel carrying one access item.
// ----------------------------------------------------------------------------
`default_nettype none

interface salwc_req_if;
  logic                              valid;
  logic                              ready;
  salwc_pkg::action_t                action;
  logic [salwc_pkg::ADDR_W-1:0]      block_addr;

  modport source (output valid, action, block_addr, input ready);
  modport sink   (input valid, action, block_addr, output ready);
endinterface

`default_nettype wire

### sv/salwc_mem_if.sv
// ----------------------------------------------------------------------------
// Cache memory request channel
// Valid/ready channel carrying one memory operation item.
// ----------------------------------------------------------------------------
`default_nettype none

interface salwc_mem_if;
  logic                              valid;
  logic                              ready;
  salwc_pkg::mem_op_t                mem_op;
  logic [salwc_pkg::ADDR_W-1:0]      mem_addr;
  logic                              last;

  modport source (output valid, mem_op, mem_addr, last, input ready);
  modport sink   (input valid, mem_op, mem_addr, last, output ready);
endinterface

`default_nettype wire

### sv/set_assoc_lru_writeback_cache_top.sv
// ----------------------------------------------------------------------------
// Set-associative LRU write-back cache controller
// Tag lookup, LRU ranking and miss/eviction request generation.
// ----------------------------------------------------------------------------
//
//   port   role    carries                      per item
//   -----  ------  ---------------------------  -------------------------
//   req    sink    action, block_addr           one cache access
//   mem    source  mem_op, mem_addr, last       one memory operation
//
// An access is accepted whenever the lookup stage is empty or finishing. The line
// RAM is read at accept and compared in the next cycle; a miss loads its first
// result into the output register once it is free; mem takes it from there.
// One access per cycle for hits, and for clean misses while mem is ready. A dirty
// eviction holds the output for two items (write-back, then read), setting the rate.
// Reset clears the valid flops only; dirty bits and ranks sit in the line RAM and
// are read for valid lines only, so no clearing pass. A stall on mem holds a miss
// in the lookup stage and drops req.ready; hits keep flowing while the output waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "set_assoc_lru_writeback_cache_top_assert.svh"

module set_assoc_lru_writeback_cache_top (
  input  wire logic   clk,
  input  wire logic   rst,
  salwc_req_if.sink   req,
  salwc_mem_if.source mem
);

  localparam int WAYS   = salwc_pkg::WAYS;
  localparam int SETS   = salwc_pkg::SETS;
  localparam int ADDR_W = salwc_pkg::ADDR_W;
  localparam int WAY_W  = salwc_pkg::WAY_W;
  localparam int SET_W  = salwc_pkg::SET_W;
  localparam int RANK_W = salwc_pkg::RANK_W;

  // One way of a line RAM row: LRU rank, dirty bit and tag.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              dirty;
    logic [ADDR_W-1:0] tag;
  } way_t;

  // Valid flops: cleared by reset.
  logic [SETS-1:0][WAYS-1:0] line_valid;

  // Line RAM: one row per set, all ways side by side.
  way_t [WAYS-1:0] line_mem [SETS];
  way_t [WAYS-1:0] row_rd;
  way_t [WAYS-1:0] byp_row;
  logic            byp_valid;
  way_t [WAYS-1:0] row_cur;
  way_t [WAYS-1:0] row_next;
  logic            row_we;
  logic            tag_we;

  // Lookup stage.
  logic                s1_valid;
  salwc_pkg::action_t  s1_action;
  logic [ADDR_W-1:0]   s1_addr;
  logic [SET_W-1:0]    s1_set;
  logic [SET_W-1:0]    in_set;

  // Output register and the pending read behind a write-back.
  logic               ovalid;
  logic               pvalid;
  salwc_pkg::result_t out_q;
  salwc_pkg::result_t pend_q;
  logic               out_wb;

  logic req_fire;
  logic mem_fire;
  logic out_free;
  logic s1_fire;

  // Lookup logic.
  logic [WAYS-1:0]             set_valid;
  logic [WAYS-1:0]             set_dirty;
  logic [WAYS-1:0][RANK_W-1:0] set_rank;
  logic [WAYS-1:0]             hit_vec;
  logic                        s1_hit;
  logic [WAY_W-1:0]            hit_way;
  logic [WAY_W-1:0]            free_way;
  logic                        set_full;
  logic [WAY_W-1:0]            victim;
  logic [WAY_W-1:0]            slot;
  logic [WAY_W-1:0]            target;
  logic                        wb_needed;
  logic [WAYS-1:0]             valid_next;
  logic [WAYS-1:0]             dirty_next;
  logic [WAYS-1:0][RANK_W-1:0] rank_next;
  salwc_pkg::result_t          first_res;
  salwc_pkg::result_t          read_res;

  // Handshakes.
  assign req_fire  = req.valid && req.ready;
  assign mem_fire  = ovalid && mem.ready;
  assign out_free  = (!ovalid || mem.ready) && !pvalid;
  // A hit needs no output slot; a miss waits for a free output.
  assign s1_fire   = s1_valid && (s1_hit || out_free);
  assign req.ready = !s1_valid || s1_fire;

  assign in_set = req.block_addr[WAY_W +: SET_W];
  assign s1_set = s1_addr[WAY_W +: SET_W];

  // Line RAM read at accept; registered data.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      row_rd  <= line_mem[in_set];
      byp_row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      line_mem[s1_set] <= row_next;
    end
  end

  // Forward a row written in the same cycle the next access reads it.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (req_fire) begin
      byp_valid <= row_we && (s1_set == in_set);
    end
  end

  assign row_cur = byp_valid ? byp_row : row_rd;

  // Lookup stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_action <= req.action;
      s1_addr   <= req.block_addr;
    end
  end

  // Tag compare, free-way search and victim choice over the set.
  always_comb begin
    set_valid = line_valid[s1_set];
    hit_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      set_dirty[w] = row_cur[w].dirty;
      set_rank[w]  = row_cur[w].rank;
      hit_vec[w]   = set_valid[w] && (row_cur[w].tag == s1_addr);
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    s1_hit   = |hit_vec;
    set_full = &set_valid;
    // Lowest free way wins.
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!set_valid[w]) begin
        free_way = WAY_W'(w);
      end
    end
    // Oldest line; on a tie the lowest way.
    victim = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (set_rank[w] > set_rank[victim]) begin
        victim = WAY_W'(w);
      end
    end
    slot      = set_full ? victim : free_way;
    target    = s1_hit ? hit_way : slot;
    wb_needed = !s1_hit && set_full && set_dirty[victim];
  end

  // Next valid, dirty and rank bits of the set.
  always_comb begin
    valid_next = set_valid;
    dirty_next = set_dirty;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == target) begin
        rank_next[w] = '0;
      end else if (set_valid[w] && (!s1_hit || set_rank[w] < set_rank[target])) begin
        rank_next[w] = set_rank[w] + RANK_W'(1);
      end else begin
        rank_next[w] = set_rank[w];
      end
    end
    if (s1_hit) begin
      if (s1_action == salwc_pkg::ACT_WRITE) begin
        dirty_next[hit_way] = 1'b1;
      end
    end else begin
      valid_next[slot] = 1'b1;
      dirty_next[slot] = (s1_action == salwc_pkg::ACT_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (s1_fire) begin
      line_valid[s1_set] <= valid_next;
    end
  end

  // Row write: new ranks and dirty bits, plus the tag on a fill.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_next[w].rank  = rank_next[w];
      row_next[w].dirty = dirty_next[w];
      row_next[w].tag   = row_cur[w].tag;
    end
    if (!s1_hit) begin
      row_next[slot].tag = s1_addr;
    end
  end

  assign row_we = s1_fire;
  assign tag_we = s1_fire && !s1_hit;

  // Miss results: optional write-back of the victim, then the read.
  always_comb begin
    read_res.mem_op   = salwc_pkg::MEM_READ;
    read_res.mem_addr = s1_addr;
    read_res.last     = 1'b1;
    if (wb_needed) begin
      first_res.mem_op   = salwc_pkg::MEM_WRITEBACK;
      first_res.mem_addr = row_cur[victim].tag;
      first_res.last     = 1'b0;
    end else begin
      first_res = read_res;
    end
  end

  // Output control: load on a miss, advance the pending read on a take.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      pvalid <= 1'b0;
    end else if (tag_we) begin
      ovalid <= 1'b1;
      pvalid <= wb_needed;
    end else if (mem_fire) begin
      if (pvalid) begin
        pvalid <= 1'b0;
      end else begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      out_q  <= first_res;
      pend_q <= read_res;
    end else if (mem_fire && pvalid) begin
      out_q <= pend_q;
    end
  end

  assign mem.valid    = ovalid;
  assign mem.mem_op   = out_q.mem_op;
  assign mem.mem_addr = out_q.mem_addr;
  assign mem.last     = out_q.last;

  assign out_wb = ovalid && out_q.mem_op == salwc_pkg::MEM_WRITEBACK && !out_q.last;

  // A pending read always sits behind a write-back on the output.
  `ASSERT_IMPL(a_pend_behind_wb, clk, rst, pvalid, out_wb)
  // A filled line is valid afterwards.
  `ASSERT_NEXT(a_fill_valid, clk, rst, tag_we, line_valid[$past(s1_set)][$past(slot)])
  // A miss waiting behind a pending read stays in the lookup stage.
  `ASSERT_NEXT(a_miss_held, clk, rst, s1_valid && !s1_hit && pvalid, s1_valid)

endmodule

`default_nettype wire
